// ----- hw/rtl/page_frame_allocator_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Page frame allocator assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PFA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("page frame allocator check failed");
`define PFA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("page frame allocator check failed");
`else
`define PFA_ASSERT(lbl, clk, rst_n, prop)
`define PFA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- hw/rtl/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Page frame allocator package
// Beat types, table entry layouts, outcome codes and default sizes.
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int FRAMES_DEF  = 16;
    localparam int CLIENTS_DEF = 16;

    localparam int ID_W    = 22;
    localparam int PAGE_W  = 16;
    localparam int CNT_W   = 16;
    localparam int TOTAL_W = 32;
    localparam int OCC_W   = 5;
    localparam int FIDX_W  = 4;

    localparam logic [OCC_W-1:0] MAX_OCC_RESET = 5'd9;

    localparam logic [1:0] OUTCOME_HIT     = 2'd0;
    localparam logic [1:0] OUTCOME_ALLOC   = 2'd1;
    localparam logic [1:0] OUTCOME_REPLACE = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   client_id;
        logic [PAGE_W-1:0] page_number;
    } t_req;

    typedef struct packed {
        logic [1:0]         outcome;
        logic [FIDX_W-1:0]  frame_index;
        logic [CNT_W-1:0]   client_faults;
        logic [TOTAL_W-1:0] total_faults;
    } t_rsp;

    typedef struct packed {
        logic [ID_W-1:0]   owner;
        logic [PAGE_W-1:0] page;
        logic [CNT_W-1:0]  use_cnt;
    } t_frame_ent;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] faults;
    } t_client_ent;

endpackage

// ----- hw/rtl/pfa_ram.sv -----
// ----------------------------------------------------------------------------
// Page frame allocator table memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int DEPTH = pfa_pkg::FRAMES_DEF,
    parameter int WIDTH = $bits(pfa_pkg::t_frame_ent),
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/page_frame_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Page frame allocator
// Each request beat names a client and a page and yields one response beat.
// The block takes one request at a time and does not accept another until
// the response register has been loaded: the frame table and the client
// table each sit in a memory with one read port, and the search walks both
// tables in step, one entry of each per cycle, followed by a drain state for
// the read pipeline and a read-modify-write state that updates both tables
// and loads the response register. A finished response waits in that
// register while the next request is scanned. max_occupancy may be written
// at any time the block is idle and is used by the next request.
// ----------------------------------------------------------------------------
`include "page_frame_allocator_unit_assert.svh"

module page_frame_allocator_unit #(
    parameter int FRAMES  = pfa_pkg::FRAMES_DEF,
    parameter int CLIENTS = pfa_pkg::CLIENTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [pfa_pkg::OCC_W-1:0]  i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  pfa_pkg::t_req              i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output pfa_pkg::t_rsp              o_out_data
);

    localparam int FW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int NSCN = (FRAMES > CLIENTS) ? FRAMES : CLIENTS;
    localparam int SW   = $clog2(NSCN);
    localparam logic [SW-1:0] LAST = SW'(NSCN - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

    t_state                          r_state;
    logic [SW-1:0]                   r_idx;
    logic [SW-1:0]                   r_pipe_idx;
    logic                            r_pipe_vld;
    pfa_pkg::t_req                   r_req;
    logic [pfa_pkg::OCC_W-1:0]       r_max_occ;
    logic [pfa_pkg::OCC_W-1:0]       r_used_cnt;
    logic [pfa_pkg::TOTAL_W-1:0]     r_total;
    logic [FRAMES-1:0]               r_frame_used;
    logic [CLIENTS-1:0]              r_cli_vld;

    logic                            r_hit;
    logic [FW-1:0]                   r_hit_idx;
    logic [pfa_pkg::CNT_W-1:0]       r_hit_use;
    logic                            r_free;
    logic [FW-1:0]                   r_free_idx;
    logic                            r_cmatch;
    logic [CW-1:0]                   r_cmatch_idx;
    logic [pfa_pkg::CNT_W-1:0]       r_cmatch_cnt;
    logic                            r_cempty;
    logic [CW-1:0]                   r_cempty_idx;
    logic [pfa_pkg::CNT_W-1:0]       r_cempty_cnt;
    logic [pfa_pkg::CNT_W-1:0]       r_c0_cnt;

    logic                            r_out_vld;
    pfa_pkg::t_rsp                   r_out;

    pfa_pkg::t_frame_ent             frm_rd;
    pfa_pkg::t_frame_ent             frm_wr;
    pfa_pkg::t_client_ent            cli_rd;
    pfa_pkg::t_client_ent            cli_ent;
    pfa_pkg::t_client_ent            cli_wr;

    logic                            in_acc;
    logic                            upd_go;
    logic                            frm_re;
    logic                            cli_re;
    logic                            frm_we;
    logic [FW-1:0]                   frm_waddr;

    logic [FW-1:0]                   f_j;
    logic [CW-1:0]                   c_j;
    logic                            f_in;
    logic                            c_in;
    logic                            f_hit_now;
    logic                            f_free_now;
    logic                            c_match_now;
    logic                            c_empty_now;
    logic                            c_zero_now;

    logic                            miss;
    logic                            alloc;
    logic [CW-1:0]                   slot;
    logic [pfa_pkg::CNT_W-1:0]       slot_cnt;
    logic [pfa_pkg::CNT_W-1:0]       new_cnt;
    logic [pfa_pkg::TOTAL_W-1:0]     new_total;
    logic [pfa_pkg::CNT_W-1:0]       new_use;
    logic [FW-1:0]                   res_idx;
    logic [FW+pfa_pkg::FIDX_W-1:0]   res_idx_ext;
    pfa_pkg::t_rsp                   rsp;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign upd_go     = (r_state == S_UPDATE) && (!r_out_vld || i_out_ready);

    // scan reads
    assign frm_re = (r_state == S_SCAN) && (int'(r_idx) < FRAMES);
    assign cli_re = (r_state == S_SCAN) && (int'(r_idx) < CLIENTS);

    pfa_ram #(
        .DEPTH (FRAMES),
        .WIDTH ($bits(pfa_pkg::t_frame_ent)),
        .AW    (FW)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (frm_we),
        .i_waddr (frm_waddr),
        .i_wdata (frm_wr),
        .i_re    (frm_re),
        .i_raddr (r_idx[FW-1:0]),
        .o_rdata (frm_rd)
    );

    pfa_ram #(
        .DEPTH (CLIENTS),
        .WIDTH ($bits(pfa_pkg::t_client_ent)),
        .AW    (CW)
    ) u_client_ram (
        .i_clk   (i_clk),
        .i_we    (upd_go),
        .i_waddr (slot),
        .i_wdata (cli_wr),
        .i_re    (cli_re),
        .i_raddr (r_idx[CW-1:0]),
        .o_rdata (cli_rd)
    );

    // compare stage
    always_comb begin
        f_j     = r_pipe_idx[FW-1:0];
        c_j     = r_pipe_idx[CW-1:0];
        f_in    = r_pipe_vld && (int'(r_pipe_idx) < FRAMES);
        c_in    = r_pipe_vld && (int'(r_pipe_idx) < CLIENTS);
        cli_ent = (c_in && r_cli_vld[c_j]) ? cli_rd : '0;

        f_hit_now  = f_in && !r_hit && r_frame_used[f_j]
                     && (frm_rd.owner == r_req.client_id)
                     && (frm_rd.page == r_req.page_number);
        f_free_now = f_in && !r_hit && !r_frame_used[f_j] && !r_free;

        c_match_now = c_in && !r_cmatch && (r_req.client_id != '0)
                      && (cli_ent.id == r_req.client_id);
        c_empty_now = c_in && !r_cempty && (cli_ent.id == '0);
        c_zero_now  = c_in && (r_pipe_idx == '0);
    end

    // update decision
    always_comb begin
        miss  = !r_hit;
        alloc = miss && (r_used_cnt < r_max_occ) && r_free;

        if (r_cmatch) begin
            slot     = r_cmatch_idx;
            slot_cnt = r_cmatch_cnt;
        end else if (r_cempty) begin
            slot     = r_cempty_idx;
            slot_cnt = r_cempty_cnt;
        end else begin
            slot     = '0;
            slot_cnt = r_c0_cnt;
        end

        new_cnt   = (miss && (slot_cnt != '1)) ? slot_cnt + 1'b1 : slot_cnt;
        new_total = (miss && (r_total != '1)) ? r_total + 1'b1 : r_total;
        new_use   = (r_hit_use != '1) ? r_hit_use + 1'b1 : r_hit_use;

        cli_wr.id     = r_req.client_id;
        cli_wr.faults = new_cnt;

        frm_we          = upd_go && (r_hit || alloc);
        frm_waddr       = r_hit ? r_hit_idx : r_free_idx;
        frm_wr.owner    = r_req.client_id;
        frm_wr.page     = r_req.page_number;
        frm_wr.use_cnt  = r_hit ? new_use : pfa_pkg::CNT_W'(1);

        if (r_hit) begin
            rsp.outcome = pfa_pkg::OUTCOME_HIT;
            res_idx     = r_hit_idx;
        end else if (alloc) begin
            rsp.outcome = pfa_pkg::OUTCOME_ALLOC;
            res_idx     = r_free_idx;
        end else begin
            rsp.outcome = pfa_pkg::OUTCOME_REPLACE;
            res_idx     = '0;
        end
        res_idx_ext       = {{pfa_pkg::FIDX_W{1'b0}}, res_idx};
        rsp.frame_index   = res_idx_ext[pfa_pkg::FIDX_W-1:0];
        rsp.client_faults = new_cnt;
        rsp.total_faults  = new_total;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_pipe_vld   <= 1'b0;
            r_max_occ    <= pfa_pkg::MAX_OCC_RESET;
            r_used_cnt   <= '0;
            r_total      <= '0;
            r_frame_used <= '0;
            r_cli_vld    <= '0;
            r_hit        <= 1'b0;
            r_free       <= 1'b0;
            r_cmatch     <= 1'b0;
            r_cempty     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_occ <= i_cfg_wdata;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state  <= S_SCAN;
                        r_idx    <= '0;
                        r_hit    <= 1'b0;
                        r_free   <= 1'b0;
                        r_cmatch <= 1'b0;
                        r_cempty <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_idx      <= r_idx + 1'b1;
                    r_pipe_vld <= 1'b1;
                    if (r_idx == LAST) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_pipe_vld <= 1'b0;
                    r_state    <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (upd_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (f_hit_now) begin
                r_hit <= 1'b1;
            end
            if (f_free_now) begin
                r_free <= 1'b1;
            end
            if (c_match_now) begin
                r_cmatch <= 1'b1;
            end
            if (c_empty_now) begin
                r_cempty <= 1'b1;
            end

            if (upd_go) begin
                r_total          <= new_total;
                r_cli_vld[slot]  <= 1'b1;
                if (alloc) begin
                    r_frame_used[r_free_idx] <= 1'b1;
                    if (r_used_cnt != '1) begin
                        r_used_cnt <= r_used_cnt + 1'b1;
                    end
                end
            end

            if (upd_go) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_pipe_idx <= r_idx;
        if (in_acc) begin
            r_req <= i_in_data;
        end
        if (f_hit_now) begin
            r_hit_idx <= f_j;
            r_hit_use <= frm_rd.use_cnt;
        end
        if (f_free_now) begin
            r_free_idx <= f_j;
        end
        if (c_match_now) begin
            r_cmatch_idx <= c_j;
            r_cmatch_cnt <= cli_ent.faults;
        end
        if (c_empty_now) begin
            r_cempty_idx <= c_j;
            r_cempty_cnt <= cli_ent.faults;
        end
        if (c_zero_now) begin
            r_c0_cnt <= cli_ent.faults;
        end
        if (upd_go) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `PFA_ASSERT(a_used_cnt_tracks_bits, i_clk, i_rst_n, $countones(r_frame_used) == int'(r_used_cnt))
    `PFA_ASSERT(a_outcome_code, i_clk, i_rst_n, o_out_valid |-> (o_out_data.outcome == pfa_pkg::OUTCOME_HIT || o_out_data.outcome == pfa_pkg::OUTCOME_ALLOC || o_out_data.outcome == pfa_pkg::OUTCOME_REPLACE))
    `PFA_ASSERT(a_replace_frame_zero, i_clk, i_rst_n, (o_out_valid && o_out_data.outcome == pfa_pkg::OUTCOME_REPLACE) |-> (o_out_data.frame_index == '0))
    `PFA_ASSERT(a_busy_after_accept, i_clk, i_rst_n, in_acc |=> (!o_in_ready && !upd_go))

endmodule

// ----- sim/page_frame_allocator_unit_checker.sv -----
// ----------------------------------------------------------------------------
// Page frame allocator checker
// Watches the request, response and limit ports of the allocator, predicts
// each response from its own frame and client tables, and compares every
// response beat field by field with the oldest prediction in order.
// ----------------------------------------------------------------------------
module page_frame_allocator_unit_checker
    import pfa_pkg::*;
#(
    parameter int FRAMES  = FRAMES_DEF,
    parameter int CLIENTS = CLIENTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [OCC_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_req             i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_rsp             i_out_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int REPORT_LIMIT = 10;

    logic [ID_W-1:0]    frame_owners [FRAMES];
    logic [PAGE_W-1:0]  frame_pages  [FRAMES];
    logic [CNT_W-1:0]   frame_uses   [FRAMES];
    logic [OCC_W-1:0]   used_frames;
    logic [OCC_W-1:0]   occ_limit;
    logic [ID_W-1:0]    client_ids   [CLIENTS];
    logic [CNT_W-1:0]   client_faults[CLIENTS];
    logic [TOTAL_W-1:0] fault_sum;

    t_rsp frame_lookup_q[$];
    int   mismatches = 0;

    function automatic t_rsp predict_lookup(input t_req req);
        t_rsp rsp;
        int   slot;
        int   free_idx;
        bit   known;
        bit   hit;
        bit   have_free;
        slot  = 0;
        known = 1'b0;
        for (int i = 0; i < CLIENTS; i++) begin
            if (!known && req.client_id != '0 && client_ids[i] == req.client_id) begin
                slot  = i;
                known = 1'b1;
            end
        end
        if (!known) begin
            for (int i = CLIENTS - 1; i >= 0; i--) begin
                if (client_ids[i] == '0)
                    slot = i;
            end
            client_ids[slot] = req.client_id;
        end

        rsp         = '0;
        rsp.outcome = OUTCOME_REPLACE;
        hit         = 1'b0;
        have_free   = 1'b0;
        free_idx    = 0;
        for (int i = 0; i < FRAMES; i++) begin
            if (!hit) begin
                if (frame_uses[i] != '0) begin
                    if (frame_owners[i] == req.client_id &&
                        frame_pages[i] == req.page_number) begin
                        hit = 1'b1;
                        if (frame_uses[i] != '1)
                            frame_uses[i]++;
                        rsp.outcome     = OUTCOME_HIT;
                        rsp.frame_index = FIDX_W'(i);
                    end
                end else if (!have_free) begin
                    free_idx  = i;
                    have_free = 1'b1;
                end
            end
        end

        if (!hit) begin
            if (used_frames < occ_limit && have_free) begin
                frame_owners[free_idx] = req.client_id;
                frame_pages[free_idx]  = req.page_number;
                frame_uses[free_idx]   = CNT_W'(1);
                if (used_frames != '1)
                    used_frames++;
                rsp.outcome     = OUTCOME_ALLOC;
                rsp.frame_index = FIDX_W'(free_idx);
            end
            if (client_faults[slot] != '1)
                client_faults[slot]++;
            if (fault_sum != '1)
                fault_sum++;
        end
        rsp.client_faults = client_faults[slot];
        rsp.total_faults  = fault_sum;
        return rsp;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < FRAMES; i++) begin
                frame_owners[i] = '0;
                frame_pages[i]  = '0;
                frame_uses[i]   = '0;
            end
            for (int i = 0; i < CLIENTS; i++) begin
                client_ids[i]    = '0;
                client_faults[i] = '0;
            end
            used_frames = '0;
            occ_limit   = MAX_OCC_RESET;
            fault_sum   = '0;
            frame_lookup_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (frame_lookup_q.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: response beat with none pending: outcome %0d frame %0d",
                                 $realtime, i_out_data.outcome, i_out_data.frame_index);
                    mismatches++;
                end else begin
                    want = frame_lookup_q.pop_front();
                    if (i_out_data.outcome !== want.outcome ||
                        i_out_data.frame_index !== want.frame_index ||
                        i_out_data.client_faults !== want.client_faults ||
                        i_out_data.total_faults !== want.total_faults) begin
                        if (mismatches < REPORT_LIMIT)
                            $display({"%0t: lookup mismatch: expected outcome %0d frame %0d ",
                                      "client %0d total %0d, got outcome %0d frame %0d ",
                                      "client %0d total %0d"},
                                     $realtime, want.outcome, want.frame_index,
                                     want.client_faults, want.total_faults,
                                     i_out_data.outcome, i_out_data.frame_index,
                                     i_out_data.client_faults, i_out_data.total_faults);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                frame_lookup_q.push_back(predict_lookup(i_in_data));
            if (i_cfg_we)
                occ_limit = i_cfg_wdata;
        end
        o_pending    <= frame_lookup_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- sim/page_frame_allocator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Page frame allocator testbench
// Drives lookup requests through directed cases and random traffic over
// several occupancy limits, with random gaps and stalls on both channels and
// one long response hold-off; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
module page_frame_allocator_unit_tb;
    import pfa_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 25;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TIMEOUT_CYCLES = 600000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int POOL_SIZE      = 8;
    localparam int RECENT_DEPTH   = 32;

    localparam logic [ID_W-1:0]   ID_MAX   = '1;
    localparam logic [PAGE_W-1:0] PAGE_MAX = '1;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [OCC_W-1:0] i_cfg_wdata = '0;
    logic             i_in_valid  = 1'b0;
    t_req             i_in_data   = '0;
    logic             i_out_ready = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    t_rsp             o_out_data;

    int fail_count;
    int pending;

    int tx_idle_pct   = 10;
    int rx_idle_pct   = 80;
    bit rx_hold_armed = 1'b0;
    int rx_hold_count = 0;

    logic [ID_W-1:0]   client_pool[POOL_SIZE];
    logic [PAGE_W-1:0] page_pool[POOL_SIZE];
    t_req              recent_reqs[$];

    page_frame_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    page_frame_allocator_unit_checker lookup_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // hold the response channel off once; otherwise stall at random
    always @(posedge i_clk) begin
        if (rx_hold_armed && rx_hold_count < RX_HOLD_CYCLES) begin
            i_out_ready   <= 1'b0;
            rx_hold_count <= rx_hold_count + 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_req(input logic [ID_W-1:0] id, input logic [PAGE_W-1:0] page);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{client_id: id, page_number: page};
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            n++;
        end while (pending != 0 && n < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_limit(input logic [OCC_W-1:0] limit);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int   roll;
        t_req req;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 45 && recent_reqs.size() != 0) begin
                req = recent_reqs[$urandom_range(recent_reqs.size() - 1)];
            end else if (roll < 75) begin
                req.client_id   = client_pool[$urandom_range(POOL_SIZE - 1)];
                req.page_number = page_pool[$urandom_range(POOL_SIZE - 1)];
            end else begin
                req.client_id   = (roll == 99) ? '0 : ID_W'($urandom_range(ID_MAX, 1));
                req.page_number = PAGE_W'($urandom_range(PAGE_MAX));
            end
            if (recent_reqs.size() < RECENT_DEPTH)
                recent_reqs.push_back(req);
            send_req(req.client_id, req.page_number);
        end
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) begin
            client_pool[i] = ID_W'($urandom_range(ID_MAX, 1));
            page_pool[i]   = PAGE_W'($urandom_range(PAGE_MAX));
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero limit: every miss needs replacement
        apply_limit(5'd0);
        send_req(ID_W'(1), '0);
        send_req(ID_MAX, PAGE_MAX);
        send_req('0, 16'h1234);

        apply_limit(5'd1);
        send_req(ID_W'(1), '0);
        send_req(ID_W'(1), '0);
        send_req(ID_W'(1), PAGE_MAX);
        send_req(ID_MAX, '0);
        send_req('0, '0);

        apply_limit(5'd4);
        send_req('0, '0);
        send_req('0, '0);
        send_req(ID_MAX, PAGE_MAX);
        send_req(22'h2AAAAA, 16'h5555);
        send_req(22'h155555, 16'hAAAA);
        send_req(ID_W'(1), '0);
        send_req(ID_MAX, PAGE_MAX);

        apply_limit(5'd9);
        run_random(360);

        apply_limit(5'd12);
        tx_idle_pct = 80;
        rx_idle_pct = 10;
        run_random(360);

        apply_limit(5'd16);
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        rx_hold_armed = 1'b1;
        run_random(180);

        // limit above the table size: a full table leaves no free frame
        apply_limit(5'd31);
        run_random(200);

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- page_frame_allocator_unit.f -----
+incdir+hw/rtl
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_ram.sv
hw/rtl/page_frame_allocator_unit.sv
sim/page_frame_allocator_unit_checker.sv
sim/page_frame_allocator_unit_tb.sv
